FILE: rtl/core/bli_pkg.sv
package bli_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned REG_W    = 8;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned LED_W    = 3;
  localparam int unsigned CNT_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN4 = 3'd0,
    REG_MIN3 = 3'd1,
    REG_MIN2 = 3'd2,
    REG_FULL = 3'd3,
    REG_MID  = 3'd4,
    REG_LOW  = 3'd5,
    REG_CRIT = 3'd6,
    REG_HYST = 3'd7
  } reg_idx_t;

  localparam logic [REG_W-1:0] RST_MIN4 = 8'd200;
  localparam logic [REG_W-1:0] RST_MIN3 = 8'd150;
  localparam logic [REG_W-1:0] RST_MIN2 = 8'd100;
  localparam logic [REG_W-1:0] RST_FULL = 8'd60;
  localparam logic [REG_W-1:0] RST_MID  = 8'd55;
  localparam logic [REG_W-1:0] RST_LOW  = 8'd50;
  localparam logic [REG_W-1:0] RST_CRIT = 8'd45;
  localparam logic [REG_W-1:0] RST_HYST = 8'd2;

  localparam logic [LED_W-1:0] LED_LOW  = 3'b001;
  localparam logic [LED_W-1:0] LED_MID  = 3'b010;
  localparam logic [LED_W-1:0] LED_TOP  = 3'b100;
  localparam logic [LED_W-1:0] LED_ALL  = 3'b111;
  localparam logic [LED_W-1:0] LED_NONE = 3'b000;

  localparam logic [CNT_W-1:0] CELLS_NONE = 3'd0;
  localparam logic [CNT_W-1:0] CELLS_2    = 3'd2;
  localparam logic [CNT_W-1:0] CELLS_3    = 3'd3;
  localparam logic [CNT_W-1:0] CELLS_4    = 3'd4;

  typedef struct packed {
    logic [REG_W-1:0] min4;
    logic [REG_W-1:0] min3;
    logic [REG_W-1:0] min2;
    logic [REG_W-1:0] full;
    logic [REG_W-1:0] mid;
    logic [REG_W-1:0] low;
    logic [REG_W-1:0] crit;
    logic [REG_W-1:0] hyst;
  } cfg_t;

  typedef struct packed {
    logic             cell_error;
    logic [CNT_W-1:0] cell_count;
    logic [LED_W-1:0] leds;
  } res_t;

  // per-cell value times cell count, low 8 bits kept
  function automatic logic [REG_W-1:0] pack_scale(input logic [REG_W-1:0] v,
                                                  input logic [CNT_W-1:0] n);
    logic [REG_W-1:0] r;
    begin
      case (n)
        CELLS_2: r = {v[REG_W-2:0], 1'b0};
        CELLS_3: r = v + {v[REG_W-2:0], 1'b0};
        CELLS_4: r = {v[REG_W-3:0], 2'b00};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/core/bli_cfg_regs.sv
module bli_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bli_pkg::IDX_W-1:0]   cfg_addr,
  input  logic [bli_pkg::REG_W-1:0]   cfg_wdata,
  output bli_pkg::cfg_t               cfg
);

  bli_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min4 <= bli_pkg::RST_MIN4;
      cfg_r.min3 <= bli_pkg::RST_MIN3;
      cfg_r.min2 <= bli_pkg::RST_MIN2;
      cfg_r.full <= bli_pkg::RST_FULL;
      cfg_r.mid  <= bli_pkg::RST_MID;
      cfg_r.low  <= bli_pkg::RST_LOW;
      cfg_r.crit <= bli_pkg::RST_CRIT;
      cfg_r.hyst <= bli_pkg::RST_HYST;
    end else if (cfg_we) begin
      case (bli_pkg::reg_idx_t'(cfg_addr))
        bli_pkg::REG_MIN4: cfg_r.min4 <= cfg_wdata;
        bli_pkg::REG_MIN3: cfg_r.min3 <= cfg_wdata;
        bli_pkg::REG_MIN2: cfg_r.min2 <= cfg_wdata;
        bli_pkg::REG_FULL: cfg_r.full <= cfg_wdata;
        bli_pkg::REG_MID:  cfg_r.mid  <= cfg_wdata;
        bli_pkg::REG_LOW:  cfg_r.low  <= cfg_wdata;
        bli_pkg::REG_CRIT: cfg_r.crit <= cfg_wdata;
        bli_pkg::REG_HYST: cfg_r.hyst <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/bli_level.sv
module bli_level (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [bli_pkg::SAMPLE_W-1:0] sample,
  input  bli_pkg::cfg_t                cfg,
  output bli_pkg::res_t                res
);

  localparam int unsigned CW = bli_pkg::REG_W + 1;

  logic                        detected_r, detected_nxt;
  logic [bli_pkg::CNT_W-1:0]   cells_r, cells_nxt;
  logic [bli_pkg::LED_W-1:0]   level_r, level_nxt;
  logic [bli_pkg::LED_W-1:0]   drive_r, drive_nxt;
  logic [bli_pkg::REG_W-1:0]   th_full_r, th_full_nxt;
  logic [bli_pkg::REG_W-1:0]   th_mid_r, th_mid_nxt;
  logic [bli_pkg::REG_W-1:0]   th_low_r, th_low_nxt;
  logic [bli_pkg::REG_W-1:0]   th_crit_r, th_crit_nxt;

  logic [bli_pkg::CNT_W-1:0]   cls;
  logic [CW-1:0]               v, full_h, mid_h, low_h, crit_h;

  always_comb begin
    if (sample > cfg.min4)      cls = bli_pkg::CELLS_4;
    else if (sample > cfg.min3) cls = bli_pkg::CELLS_3;
    else if (sample > cfg.min2) cls = bli_pkg::CELLS_2;
    else                        cls = bli_pkg::CELLS_NONE;
  end

  // threshold plus hysteresis at 9 bits, no wrap
  assign v      = {1'b0, sample};
  assign full_h = {1'b0, th_full_r} + {1'b0, cfg.hyst};
  assign mid_h  = {1'b0, th_mid_r}  + {1'b0, cfg.hyst};
  assign low_h  = {1'b0, th_low_r}  + {1'b0, cfg.hyst};
  assign crit_h = {1'b0, th_crit_r} + {1'b0, cfg.hyst};

  always_comb begin
    detected_nxt = detected_r;
    cells_nxt    = cells_r;
    level_nxt    = level_r;
    drive_nxt    = drive_r;
    th_full_nxt  = th_full_r;
    th_mid_nxt   = th_mid_r;
    th_low_nxt   = th_low_r;
    th_crit_nxt  = th_crit_r;
    if (!detected_r) begin
      detected_nxt = 1'b1;
      cells_nxt    = cls;
      th_full_nxt  = bli_pkg::pack_scale(cfg.full, cls);
      th_mid_nxt   = bli_pkg::pack_scale(cfg.mid, cls);
      th_low_nxt   = bli_pkg::pack_scale(cfg.low, cls);
      th_crit_nxt  = bli_pkg::pack_scale(cfg.crit, cls);
      level_nxt    = bli_pkg::LED_ALL;
      drive_nxt    = bli_pkg::LED_ALL;
    end else if (cells_r != bli_pkg::CELLS_NONE) begin
      if (((level_r & bli_pkg::LED_TOP) != '0) && (sample < th_full_r)) begin
        level_nxt = bli_pkg::LED_LOW | bli_pkg::LED_MID;
        drive_nxt = bli_pkg::LED_LOW | bli_pkg::LED_MID;
      end else if ((level_r & bli_pkg::LED_MID) != '0) begin
        if (v > full_h) begin
          level_nxt = bli_pkg::LED_ALL;
          drive_nxt = bli_pkg::LED_ALL;
        end else if (sample < th_mid_r) begin
          level_nxt = bli_pkg::LED_LOW;
          drive_nxt = bli_pkg::LED_LOW;
        end
      end else if ((level_r & bli_pkg::LED_LOW) != '0) begin
        if (v > mid_h) begin
          level_nxt = bli_pkg::LED_LOW | bli_pkg::LED_MID;
          drive_nxt = bli_pkg::LED_LOW | bli_pkg::LED_MID;
        end else if (sample < th_low_r) begin
          level_nxt = bli_pkg::LED_NONE;
          drive_nxt = bli_pkg::LED_NONE;
        end
      end else begin
        if (v > low_h) begin
          level_nxt = bli_pkg::LED_LOW;
          drive_nxt = bli_pkg::LED_LOW;
        end else if (v > crit_h) begin
          level_nxt = bli_pkg::LED_NONE;
          drive_nxt = bli_pkg::LED_NONE;
        end else begin
          drive_nxt = ~drive_r; // blink
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detected_r <= 1'b0;
      cells_r    <= bli_pkg::CELLS_NONE;
      level_r    <= bli_pkg::LED_ALL;
      drive_r    <= bli_pkg::LED_ALL;
    end else if (step) begin
      detected_r <= detected_nxt;
      cells_r    <= cells_nxt;
      level_r    <= level_nxt;
      drive_r    <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      th_full_r <= th_full_nxt;
      th_mid_r  <= th_mid_nxt;
      th_low_r  <= th_low_nxt;
      th_crit_r <= th_crit_nxt;
    end
  end

  assign res.leds       = drive_nxt;
  assign res.cell_count = cells_nxt;
  assign res.cell_error = detected_nxt && (cells_nxt == bli_pkg::CELLS_NONE);

endmodule

FILE: rtl/core/battery_level_led_indicator_core.sv
// Battery level LED indicator.
// in_*  : one 8-bit voltage sample per request (in_tdata[7:0]).
// out_* : one result per sample; out_tdata = leds[2:0], cell_count[5:3],
//         cell_error[6], bit 7 zero.
// cfg_* : register write, index 0..7, taken on the clock edge whenever cfg_we
//         is high; write only while no request is in flight.
// The first sample after reset fixes the cell count and pack thresholds. With
// cells found, later ones step the bar with hysteresis or blink at the bottom.
// out_tvalid rises once an accepted sample has passed the input register,
// then the result register. Throughput: one sample per cycle unless stalled;
// the bar state update is one pass of compares between the two registers.
// A stalled out_tready holds the result; one more sample may wait in the
// input register, after which in_tready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, restores the
// register defaults and returns the bar to all LEDs on, cell count unknown.
module battery_level_led_indicator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] sample
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] leds, [5:3] cell_count, [6] cell_error, [7] zero
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);

  bli_pkg::cfg_t                 cfg;
  bli_pkg::res_t                 res;

  logic                          s1_valid_r;
  logic [bli_pkg::SAMPLE_W-1:0]  s1_sample_r;
  logic                          out_valid_r;
  bli_pkg::res_t                 out_res_r;
  logic                          s1_adv;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  bli_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bli_level u_level (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_sample_r <= in_tdata;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

endmodule
